FILE: rtl/kct_pkg.sv
package kct_pkg;

	// Fixed field widths of the request and response items.
	localparam int unsigned KEY_W = 48;
	localparam int unsigned CNT_W = 32;
	localparam int unsigned ACTION_W = 3;

	// Action codes carried in a request.
	localparam logic [ACTION_W-1:0] ACTION_ADD    = 3'd0;
	localparam logic [ACTION_W-1:0] ACTION_TAKE   = 3'd1;
	localparam logic [ACTION_W-1:0] ACTION_REMOVE = 3'd2;
	localparam logic [ACTION_W-1:0] ACTION_COUNT  = 3'd3;
	localparam logic [ACTION_W-1:0] ACTION_REPORT = 3'd4;

	// Response kinds.
	localparam logic KIND_COUNT  = 1'b0;
	localparam logic KIND_REPORT = 1'b1;

	// Saturation bounds of a count.
	localparam logic signed [CNT_W-1:0] CNT_MAX = 32'sh7fff_ffff;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [ACTION_W-1:0]     action;
		logic [KEY_W-1:0]        key;
		logic signed [CNT_W-1:0] amount;
	} kct_req_t;

	typedef struct packed {
		logic                    kind;
		logic [KEY_W-1:0]        entry_key;
		logic signed [CNT_W-1:0] entry_count;
		logic                    last;
	} kct_rsp_t;

endpackage

FILE: rtl/keyed_counter_table.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  kct_req_t (action, key, amount)
// rsp       out        rsp_valid / rsp_stall  kct_rsp_t (kind, entry_key, entry_count, last)
//
// One request is handled at a time; req_stall is high outside the idle state.
// Add, take, count and remove look up their key by a linear search through the single read
// port; the first match ends the search. Remove then shifts every later entry down one place.
// Report sends one response per cycle while rsp_stall is low.
// Reset clears the fill level and the response register; the memory is not cleared.
module keyed_counter_table #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned KEY_BITS = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  kct_pkg::kct_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output kct_pkg::kct_rsp_t rsp
);

	localparam int unsigned KW = (KEY_BITS < kct_pkg::KEY_W) ? KEY_BITS : kct_pkg::KEY_W;
	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam int unsigned MW = KW + kct_pkg::CNT_W;
	localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ACT,
		ST_SHIFT,
		ST_REPORT
	} state_t;

	state_t state_q;

	logic [kct_pkg::ACTION_W-1:0]     action_q;
	logic [KW-1:0]                    key_q;
	logic signed [kct_pkg::CNT_W-1:0] amount_q;
	logic [FW-1:0]                    fill_q;
	logic [FW-1:0]                    rd_idx_q;
	logic                             found_q;
	logic [IW-1:0]                    pos_q;
	logic signed [kct_pkg::CNT_W-1:0] cnt_q;
	logic                             s1_vld_s1;
	logic [IW-1:0]                    idx_s1;
	logic                             rsp_vld_q;
	kct_pkg::kct_rsp_t                rsp_q;

	logic                             rd_en;
	logic [MW-1:0]                    rd_data;
	logic [KW-1:0]                    rd_key;
	logic signed [kct_pkg::CNT_W-1:0] rd_count;
	logic                             wr_en;
	logic [IW-1:0]                    wr_addr;
	logic [MW-1:0]                    wr_data;
	logic signed [kct_pkg::CNT_W-1:0] alu_result;
	logic                             rsp_free;
	logic                             rsp_load;
	logic                             more;
	logic                             idx_last;
	logic                             appended;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_vld_q;
	assign rsp = rsp_q;

	assign rd_key = rd_data[MW-1:kct_pkg::CNT_W];
	assign rd_count = rd_data[kct_pkg::CNT_W-1:0];
	assign rsp_free = !rsp_vld_q || !rsp_stall;
	assign more = (rd_idx_q < fill_q);
	assign idx_last = ((FW'(idx_s1) + FW'(1)) == fill_q);
	assign appended = (state_q == ST_ACT) && (action_q == kct_pkg::ACTION_ADD) &&
		!found_q && (fill_q < DEPTH_F);

	// A count reply or a report entry enters the response register when it is free.
	assign rsp_load = rsp_free &&
		(((state_q == ST_ACT) && (action_q == kct_pkg::ACTION_COUNT)) ||
		((state_q == ST_REPORT) && s1_vld_s1));

	// Table memory: key in the upper bits, count in the lower bits.
	kct_ram #(
		.WIDTH(MW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q[IW-1:0]),
		.rd_data(rd_data)
	);

	// Saturating add or take on the count found by the search.
	kct_alu u_alu (
		.take  (action_q == kct_pkg::ACTION_TAKE),
		.count (cnt_q),
		.amount(amount_q),
		.result(alu_result)
	);

	// Read issue: one entry per cycle; a report waits on the response register.
	always_comb begin
		unique case (state_q)
			ST_SEARCH, ST_SHIFT: rd_en = more;
			ST_REPORT:           rd_en = more && (!s1_vld_s1 || rsp_free);
			default:             rd_en = 1'b0;
		endcase
	end

	// Write-back of an updated or appended entry, and the shift-down copy.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = pos_q;
		wr_data = {key_q, alu_result};
		if (state_q == ST_ACT) begin
			if (found_q && (action_q == kct_pkg::ACTION_ADD ||
					action_q == kct_pkg::ACTION_TAKE)) begin
				wr_en = 1'b1;
			end else if (appended) begin
				wr_en = 1'b1;
				wr_addr = fill_q[IW-1:0];
				wr_data = {key_q, amount_q};
			end
		end else if (state_q == ST_SHIFT && s1_vld_s1) begin
			wr_en = 1'b1;
			wr_addr = idx_s1 - IW'(1);
			wr_data = rd_data;
		end
	end

	// Sequencer, read pipeline and response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			s1_vld_s1 <= 1'b0;
			rsp_vld_q <= 1'b0;
			rsp_q <= '0;
			rd_idx_q <= '0;
			found_q <= 1'b0;
			action_q <= '0;
			key_q <= '0;
			amount_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			idx_s1 <= '0;
		end else begin
			// The response register fills on a load and drains when the far side takes it.
			if (rsp_load) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end

			// Track the entry index that the read data belongs to.
			if (state_q == ST_REPORT) begin
				s1_vld_s1 <= rd_en || (s1_vld_s1 && !rsp_free);
			end else if (state_q == ST_SEARCH || state_q == ST_SHIFT) begin
				s1_vld_s1 <= rd_en;
			end else begin
				s1_vld_s1 <= 1'b0;
			end
			if (rd_en) begin
				idx_s1 <= rd_idx_q[IW-1:0];
				rd_idx_q <= rd_idx_q + FW'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						action_q <= req.action;
						key_q <= req.key[KW-1:0];
						amount_q <= req.amount;
						rd_idx_q <= '0;
						found_q <= 1'b0;
						if (req.action == kct_pkg::ACTION_ADD ||
								req.action == kct_pkg::ACTION_TAKE ||
								req.action == kct_pkg::ACTION_REMOVE ||
								req.action == kct_pkg::ACTION_COUNT) begin
							state_q <= ST_SEARCH;
						end else if (req.action == kct_pkg::ACTION_REPORT) begin
							state_q <= ST_REPORT;
						end
					end
				end
				ST_SEARCH: begin
					// The first matching key ends the search.
					if (s1_vld_s1 && rd_key == key_q) begin
						found_q <= 1'b1;
						pos_q <= idx_s1;
						cnt_q <= rd_count;
						state_q <= ST_ACT;
					end else if (!s1_vld_s1 && !more) begin
						found_q <= 1'b0;
						cnt_q <= '0;
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					unique case (action_q)
						kct_pkg::ACTION_REMOVE: begin
							if (found_q) begin
								rd_idx_q <= FW'(pos_q) + FW'(1);
								state_q <= ST_SHIFT;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						kct_pkg::ACTION_COUNT: begin
							if (rsp_free) begin
								rsp_q.kind <= kct_pkg::KIND_COUNT;
								rsp_q.entry_key <= kct_pkg::KEY_W'(key_q);
								rsp_q.entry_count <= cnt_q;
								rsp_q.last <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						default: begin
							if (appended) begin
								fill_q <= fill_q + FW'(1);
							end
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SHIFT: begin
					if (!s1_vld_s1 && !more) begin
						fill_q <= fill_q - FW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_REPORT: begin
					if (s1_vld_s1 && rsp_free) begin
						rsp_q.kind <= kct_pkg::KIND_REPORT;
						rsp_q.entry_key <= kct_pkg::KEY_W'(rd_key);
						rsp_q.entry_count <= rd_count;
						rsp_q.last <= idx_last;
					end
					if (!s1_vld_s1 && !more) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// The fill level never passes the table depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= DEPTH_F)
		else $error("fill level above depth");

	// The fill level moves by one entry at most per cycle.
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fill_q) |-> (fill_q == $past(fill_q) + FW'(1) ||
			fill_q == $past(fill_q) - FW'(1)))
		else $error("fill level jumped");

	// Memory writes happen only at write-back or during the shift-down.
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_ACT || state_q == ST_SHIFT))
		else $error("memory write outside write-back");

	// A shift copy lands below the last occupied entry.
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && wr_en) |-> ((FW'(wr_addr) + FW'(1)) < fill_q))
		else $error("shift write beyond table");

	// A request is taken only in the idle state, and a report request starts
	// a report.
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.action == kct_pkg::ACTION_REPORT)
			|=> (state_q == ST_REPORT))
		else $error("report request did not start a report");
`endif

endmodule

FILE: rtl/kct_ram.sv
module kct_ram #(
	parameter int unsigned WIDTH = 80,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

FILE: rtl/kct_alu.sv
module kct_alu (
	input  logic                             take,
	input  logic signed [kct_pkg::CNT_W-1:0] count,
	input  logic signed [kct_pkg::CNT_W-1:0] amount,
	output logic signed [kct_pkg::CNT_W-1:0] result
);

	logic signed [kct_pkg::CNT_W:0] count_x;
	logic signed [kct_pkg::CNT_W:0] amount_x;
	logic signed [kct_pkg::CNT_W:0] sum;
	logic signed [kct_pkg::CNT_W-1:0] sat;

	// Widen by one bit so the add or subtract cannot wrap.
	assign count_x = {count[kct_pkg::CNT_W-1], count};
	assign amount_x = {amount[kct_pkg::CNT_W-1], amount};
	assign sum = take ? (count_x - amount_x) : (count_x + amount_x);

	// Saturate when the top two bits disagree, then clamp a take at zero.
	always_comb begin
		if (sum[kct_pkg::CNT_W] != sum[kct_pkg::CNT_W-1]) begin
			sat = sum[kct_pkg::CNT_W] ? kct_pkg::CNT_MIN : kct_pkg::CNT_MAX;
		end else begin
			sat = sum[kct_pkg::CNT_W-1:0];
		end
		if (take && sat[kct_pkg::CNT_W-1]) begin
			result = '0;
		end else begin
			result = sat;
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

import kct_pkg::*;

// Tracks the table contents and the responses each accepted request should produce.
class counter_table_tracker;
	localparam int ROWS = 32;

	logic [KEY_W-1:0]        keys[ROWS];
	logic signed [CNT_W-1:0] counts[ROWS];
	int                      used;
	kct_rsp_t                expected_rows[$];
	int                      faults;

	function new();
		used = 0;
		faults = 0;
	endfunction

	// Limits a wide result to the signed count range.
	function logic signed [CNT_W-1:0] clamp(longint v);
		if (v > longint'(CNT_MAX))
			return CNT_MAX;
		if (v < longint'(CNT_MIN))
			return CNT_MIN;
		return v[CNT_W-1:0];
	endfunction

	function string show(kct_rsp_t r);
		return $sformatf("kind=%0d key=%h count=%0d last=%0d",
			r.kind, r.entry_key, r.entry_count, r.last);
	endfunction

	// Only the first ten faults are printed; the rest are counted.
	function void flag(string what, string detail);
		faults++;
		if (faults <= 10)
			$display("%s: %s", what, detail);
	endfunction

	// Applies one request to the table copy and queues the responses it causes.
	function void note_request(kct_req_t r);
		int                      slot;
		logic signed [CNT_W-1:0] c;
		kct_rsp_t                row;
		slot = -1;
		for (int i = used - 1; i >= 0; i--)
			if (keys[i] == r.key)
				slot = i;
		case (r.action)
			ACTION_ADD: begin
				if (slot >= 0) begin
					counts[slot] = clamp(longint'(counts[slot]) + longint'(r.amount));
				end else if (used < ROWS) begin
					keys[used] = r.key;
					counts[used] = r.amount;
					used++;
				end
			end
			ACTION_TAKE: begin
				if (slot >= 0) begin
					c = clamp(longint'(counts[slot]) - longint'(r.amount));
					counts[slot] = (c < 0) ? '0 : c;
				end
			end
			ACTION_REMOVE: begin
				if (slot >= 0) begin
					for (int i = slot; i + 1 < used; i++) begin
						keys[i] = keys[i + 1];
						counts[i] = counts[i + 1];
					end
					used--;
				end
			end
			ACTION_COUNT: begin
				row.kind = KIND_COUNT;
				row.entry_key = r.key;
				row.entry_count = (slot >= 0) ? counts[slot] : '0;
				row.last = 1'b1;
				expected_rows.push_back(row);
			end
			ACTION_REPORT: begin
				for (int i = 0; i < used; i++) begin
					row.kind = KIND_REPORT;
					row.entry_key = keys[i];
					row.entry_count = counts[i];
					row.last = (i == used - 1);
					expected_rows.push_back(row);
				end
			end
			default: ;
		endcase
	endfunction

	// Compares an accepted response with the oldest queued one.
	function void check_response(kct_rsp_t got);
		kct_rsp_t want;
		if (expected_rows.size() == 0) begin
			flag("unexpected response", show(got));
			return;
		end
		want = expected_rows.pop_front();
		if (got.kind !== want.kind || got.entry_key !== want.entry_key ||
				got.entry_count !== want.entry_count || got.last !== want.last)
			flag("wrong response", {"expected ", show(want), ", got ", show(got)});
	endfunction

	// Anything still queued at the end never arrived.
	function void close_out();
		while (expected_rows.size() != 0)
			flag("missing response", show(expected_rows.pop_front()));
	endfunction
endclass

module tb;
	localparam int TABLE_DEPTH = 32;
	localparam int POOL_SIZE = 40;
	localparam int MIXED_REQUESTS = 60;
	localparam int LONG_HOLD = 400;
	localparam int SETTLE = 80;
	localparam logic [ACTION_W-1:0] ACTION_NONE_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACTION_NONE_LAST = 3'd7;

	logic     clk;
	logic     arst_n = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	kct_req_t req = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	kct_rsp_t rsp;

	counter_table_tracker tracker;
	logic [KEY_W-1:0]     key_pool[POOL_SIZE];
	bit                   long_hold_pending = 1'b0;
	int                   send_calm = 0;
	int                   recv_calm = 0;

	keyed_counter_table #(
		.DEPTH(TABLE_DEPTH),
		.KEY_BITS(KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard limit on the run.
	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Idle cycles before the next request or response, with calm stretches of none.
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0)
			calm = $urandom_range(10, 30);
		return $urandom_range(0, 19);
	endfunction

	// Amounts lean toward the saturation bounds and small values.
	function automatic logic signed [CNT_W-1:0] rand_amount();
		case ($urandom_range(0, 5))
			0: return CNT_MAX;
			1: return CNT_MIN;
			2: return CNT_W'($urandom_range(0, 200) - 100);
			default: return CNT_W'($urandom);
		endcase
	endfunction

	// Offers one request after a random gap and returns at the edge that accepts it.
	task automatic send_request(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key,
			logic signed [CNT_W-1:0] amount);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{action: action, key: key, amount: amount};
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Stops offering requests until every queued response has arrived.
	task automatic wait_for_drain();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.expected_rows.size() != 0);
	endtask

	// Both handshakes are sampled at the edge that completes them.
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			tracker.note_request(req);
		if (arst_n && rsp_valid && !rsp_stall)
			tracker.check_response(rsp);
	end

	// Response side: stall for a random time, then take one response.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = draw_gap(recv_calm);
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid)
				@(posedge clk);
		end
	end

	initial begin
		int                  pick;
		logic [KEY_W-1:0]    k;
		logic [ACTION_W-1:0] act;
		tracker = new();
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'({$urandom, $urandom});
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, both saturation bounds, clamping and absent keys.
		send_request(ACTION_REPORT, '0, '0);
		send_request(ACTION_COUNT, '0, '0);
		send_request(ACTION_ADD, '0, CNT_MAX);
		send_request(ACTION_ADD, '0, 32'sd1);
		send_request(ACTION_ADD, '1, CNT_MIN);
		send_request(ACTION_ADD, '1, -32'sd1);
		send_request(ACTION_COUNT, '1, CNT_MAX);
		send_request(ACTION_TAKE, '1, 32'sd5);
		send_request(ACTION_TAKE, '0, CNT_MIN);
		send_request(ACTION_TAKE, 48'h123, 32'sd7);
		send_request(ACTION_REMOVE, 48'h456, '0);
		send_request(ACTION_NONE_FIRST, '0, '1);
		send_request(ACTION_NONE_LAST, '1, '1);
		send_request(ACTION_ADD, 48'h5a5a, 32'sd10);
		send_request(ACTION_REPORT, '1, CNT_MAX);
		// Removing the head shifts the later entries down.
		send_request(ACTION_REMOVE, '0, 32'sd3);
		send_request(ACTION_REPORT, '0, '0);
		send_request(ACTION_TAKE, 48'h5a5a, -32'sd20);
		send_request(ACTION_COUNT, 48'h5a5a, CNT_MIN);
		send_request(ACTION_REMOVE, 48'h5a5a, '0);
		send_request(ACTION_REMOVE, '1, '0);
		send_request(ACTION_COUNT, '1, '0);

		// Fill the table with distinct keys; the adds past its depth are dropped.
		for (int i = 0; i < TABLE_DEPTH + 3; i++)
			send_request(ACTION_ADD, key_pool[i], rand_amount());
		send_request(ACTION_COUNT, key_pool[TABLE_DEPTH], '0);

		// Let everything drain, then hold the response side off during a full report.
		wait_for_drain();
		long_hold_pending = 1'b1;
		send_request(ACTION_REPORT, '0, '0);

		// Mixed traffic, mostly on pooled keys so that lookups hit.
		for (int n = 0; n < MIXED_REQUESTS; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 9) == 0)
				k = KEY_W'({$urandom, $urandom});
			else
				k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
			if (pick < 40)
				act = ACTION_ADD;
			else if (pick < 55)
				act = ACTION_TAKE;
			else if (pick < 67)
				act = ACTION_REMOVE;
			else if (pick < 85)
				act = ACTION_COUNT;
			else if (pick < 93)
				act = ACTION_REPORT;
			else
				act = ACTION_W'($urandom_range(ACTION_NONE_FIRST, ACTION_NONE_LAST));
			send_request(act, k, rand_amount());
		end

		// Wait for the last responses, then watch for stray ones.
		wait_for_drain();
		repeat (SETTLE) @(posedge clk);
		tracker.close_out();
		if (tracker.faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
